// ----- src/cfr_pkg.sv -----
// Shared types and constants for the CAN fragment reassembler.
`default_nettype none
package cfr_pkg;

  localparam int MAX_PARTS   = 32;
  localparam int CHUNK_BYTES = 6;
  localparam int IDX_W       = $clog2(MAX_PARTS);
  localparam int CNT_W       = IDX_W + 1;
  localparam int DATA_W      = 8 * CHUNK_BYTES;

  localparam logic [31:0] TIMEOUT_RESET = 32'd1000;
  localparam logic [3:0]  DLC_MAX       = 4'd8;
  localparam logic [3:0]  HDR_BYTES     = 4'd2;

  typedef enum logic [1:0] {
    STATUS_PEND   = 2'd0,
    STATUS_REJECT = 2'd1,
    STATUS_DONE   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPDATE,
    S_EMIT,
    S_DRAIN
  } state_t;

  typedef struct packed {
    logic [10:0] frame_id;
    logic [3:0]  length_code;
    logic [7:0]  count_minus_one;
    logic [7:0]  sequence_req;
    logic [7:0]  data_0;
    logic [7:0]  data_1;
    logic [7:0]  data_2;
    logic [7:0]  data_3;
    logic [7:0]  data_4;
    logic [7:0]  data_5;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [2:0]  chunk_len;
    logic [7:0]  out_0;
    logic [7:0]  out_1;
    logic [7:0]  out_2;
    logic [7:0]  out_3;
    logic [7:0]  out_4;
    logic [7:0]  out_5;
    logic [7:0]  packet_len;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [2:0]        size;
    logic [DATA_W-1:0] bytes;
  } entry_t;

endpackage
`default_nettype wire

// ----- src/cfr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- src/can_fragment_reassembler_unit.sv -----
// Top level of the CAN fragment reassembler: control, valid bits and chunk RAM.
`default_nettype none
// An item is taken when start is high and busy is low. A rejected or duplicate
// fragment gives one result in the cycle after it is taken, and busy stays low.
// A fragment that is stored keeps busy high while its RAM slot is read, updated
// and written back in the update state; if the packet is still pending, its
// result is registered in that state. A fragment that completes the packet then
// streams the N stored chunks out of the chunk RAM, one read per cycle through its
// single read port, and its results come on consecutive cycles, each passing the
// registered RAM read and then the result register, the final one flagged
// by last. The done strobe marks each result for one cycle; there is no way to
// stall it. Configuration writes take effect at the next edge.
module can_fragment_reassembler_unit (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output      logic            busy,
  input  wire cfr_pkg::item_t  item,
  output      logic            done,
  output      cfr_pkg::result_t result,
  input  wire logic            cfg_we,
  input  wire logic [31:0]     cfg_wdata
);

  cfr_pkg::state_t                state, state_next;
  logic                           in_progress, in_progress_next;
  logic [cfr_pkg::CNT_W-1:0]      expected, expected_next;
  logic [cfr_pkg::MAX_PARTS-1:0]  got_mask, got_mask_next;
  logic [10:0]                    prev_id, prev_id_next;
  logic [7:0]                     prev_seq, prev_seq_next;
  logic [31:0]                    last_seen, last_seen_next;
  logic [31:0]                    timeout;
  logic [7:0]                     sum, sum_next;
  logic [cfr_pkg::IDX_W-1:0]      idx, idx_next;
  logic                           rd_pend, rd_pend_next;
  logic                           rd_last, rd_last_next;
  logic                           done_next;
  cfr_pkg::result_t               result_next;
  logic [cfr_pkg::IDX_W-1:0]      cur_seq, cur_seq_next;
  logic [2:0]                     cur_plen, cur_plen_next;
  logic [cfr_pkg::DATA_W-1:0]     cur_bytes, cur_bytes_next;

  logic                           ram_we;
  logic [cfr_pkg::IDX_W-1:0]      ram_raddr;
  cfr_pkg::entry_t                ram_wentry;
  cfr_pkg::entry_t                ram_rentry;

  // Decode of the incoming item
  logic [3:0]                     dlc_sat;
  logic [3:0]                     plen_full;
  logic [2:0]                     plen;
  logic [7:0]                     total;
  logic [31:0]                    gap;
  logic                           restart;
  logic [cfr_pkg::CNT_W-1:0]      exp_eff;
  logic                           is_short;
  logic                           bad_count;
  logic                           bad_seq;
  logic                           is_dup;

  // Update-cycle helpers
  logic [2:0]                     old_size;
  logic [8:0]                     sum_calc;
  logic [cfr_pkg::MAX_PARTS-1:0]  mask_new;
  logic [cfr_pkg::MAX_PARTS-1:0]  need_mask;
  logic                           complete;
  logic [7:0]                     ob [cfr_pkg::CHUNK_BYTES];

  assign busy = (state != cfr_pkg::S_IDLE);

  cfr_ram #(
    .WIDTH ($bits(cfr_pkg::entry_t)),
    .DEPTH (cfr_pkg::MAX_PARTS)
  ) u_chunk_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur_seq),
    .wdata (ram_wentry),
    .raddr (ram_raddr),
    .rdata (ram_rentry)
  );

  assign ram_wentry.size  = cur_plen;
  assign ram_wentry.bytes = cur_bytes;

  always_comb begin
    dlc_sat   = (item.length_code > cfr_pkg::DLC_MAX) ? cfr_pkg::DLC_MAX : item.length_code;
    is_short  = (dlc_sat < cfr_pkg::HDR_BYTES);
    plen_full = dlc_sat - cfr_pkg::HDR_BYTES;
    plen      = (plen_full > 4'(cfr_pkg::CHUNK_BYTES)) ? 3'(cfr_pkg::CHUNK_BYTES)
                                                        : plen_full[2:0];
    total     = item.count_minus_one + 8'd1;
    bad_count = (total == 8'd0) || (total > 8'(cfr_pkg::MAX_PARTS));
    gap       = item.now_ms - last_seen;
    restart   = !in_progress || (gap > timeout);
    exp_eff   = restart ? total[cfr_pkg::CNT_W-1:0] : expected;
    bad_seq   = (item.sequence_req >= 8'(exp_eff));
    is_dup    = (item.frame_id == prev_id) && (item.sequence_req == prev_seq);
  end

  always_comb begin
    old_size = got_mask[cur_seq] ? ram_rentry.size : 3'd0;
    sum_calc = {1'b0, sum} - {6'd0, old_size} + {6'd0, cur_plen};
    mask_new = got_mask | (cfr_pkg::MAX_PARTS'(1) << cur_seq);
    for (int i = 0; i < cfr_pkg::MAX_PARTS; i++) begin
      need_mask[i] = (cfr_pkg::CNT_W'(i) < expected);
    end
    complete = &(mask_new | ~need_mask);
    for (int b = 0; b < cfr_pkg::CHUNK_BYTES; b++) begin
      ob[b] = (3'(b) < ram_rentry.size) ? ram_rentry.bytes[8*b +: 8] : 8'd0;
    end
  end

  always_comb begin
    state_next       = state;
    in_progress_next = in_progress;
    expected_next    = expected;
    got_mask_next    = got_mask;
    prev_id_next     = prev_id;
    prev_seq_next    = prev_seq;
    last_seen_next   = last_seen;
    sum_next         = sum;
    idx_next         = idx;
    rd_pend_next     = 1'b0;
    rd_last_next     = 1'b0;
    done_next        = 1'b0;
    result_next      = result;
    cur_seq_next     = cur_seq;
    cur_plen_next    = cur_plen;
    cur_bytes_next   = cur_bytes;
    ram_we           = 1'b0;
    ram_raddr        = item.sequence_req[cfr_pkg::IDX_W-1:0];

    // Stream out a chunk read in the previous cycle
    if (rd_pend) begin
      done_next              = 1'b1;
      result_next.status     = cfr_pkg::STATUS_DONE;
      result_next.chunk_len  = ram_rentry.size;
      result_next.out_0      = ob[0];
      result_next.out_1      = ob[1];
      result_next.out_2      = ob[2];
      result_next.out_3      = ob[3];
      result_next.out_4      = ob[4];
      result_next.out_5      = ob[5];
      result_next.packet_len = sum;
      result_next.last       = rd_last;
    end

    unique case (state)
      cfr_pkg::S_IDLE: begin
        if (start) begin
          done_next   = 1'b1;
          result_next = '0;
          result_next.last = 1'b1;
          if (is_short || bad_count) begin
            result_next.status = cfr_pkg::STATUS_REJECT;
          end else begin
            if (restart) begin
              in_progress_next = 1'b1;
              expected_next    = total[cfr_pkg::CNT_W-1:0];
              got_mask_next    = '0;
              sum_next         = '0;
            end
            if (bad_seq) begin
              result_next.status = cfr_pkg::STATUS_REJECT;
            end else if (is_dup) begin
              result_next.status = cfr_pkg::STATUS_PEND;
            end else begin
              // Hold the fragment; the slot's old size comes back next cycle
              done_next      = 1'b0;
              prev_id_next   = item.frame_id;
              prev_seq_next  = item.sequence_req;
              last_seen_next = item.now_ms;
              cur_seq_next   = item.sequence_req[cfr_pkg::IDX_W-1:0];
              cur_plen_next  = plen;
              cur_bytes_next = {item.data_5, item.data_4, item.data_3,
                                item.data_2, item.data_1, item.data_0};
              state_next     = cfr_pkg::S_UPDATE;
            end
          end
        end
      end
      cfr_pkg::S_UPDATE: begin
        ram_we        = 1'b1;
        got_mask_next = mask_new;
        sum_next      = sum_calc[7:0];
        if (complete) begin
          idx_next   = '0;
          state_next = cfr_pkg::S_EMIT;
        end else begin
          done_next          = 1'b1;
          result_next        = '0;
          result_next.status = cfr_pkg::STATUS_PEND;
          result_next.last   = 1'b1;
          state_next         = cfr_pkg::S_IDLE;
        end
      end
      cfr_pkg::S_EMIT: begin
        ram_raddr    = idx;
        rd_pend_next = 1'b1;
        rd_last_next = ({1'b0, idx} == expected - cfr_pkg::CNT_W'(1));
        if (rd_last_next) begin
          state_next = cfr_pkg::S_DRAIN;
        end else begin
          idx_next = idx + cfr_pkg::IDX_W'(1);
        end
      end
      cfr_pkg::S_DRAIN: begin
        // Final chunk's result is registered this cycle; drop the packet
        in_progress_next = 1'b0;
        got_mask_next    = '0;
        state_next       = cfr_pkg::S_IDLE;
      end
      default: begin
        state_next = cfr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= cfr_pkg::S_IDLE;
      in_progress <= 1'b0;
      expected    <= '0;
      got_mask    <= '0;
      prev_id     <= '0;
      prev_seq    <= '0;
      last_seen   <= '0;
      timeout     <= cfr_pkg::TIMEOUT_RESET;
      rd_pend     <= 1'b0;
      rd_last     <= 1'b0;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      in_progress <= in_progress_next;
      expected    <= expected_next;
      got_mask    <= got_mask_next;
      prev_id     <= prev_id_next;
      prev_seq    <= prev_seq_next;
      last_seen   <= last_seen_next;
      rd_pend     <= rd_pend_next;
      rd_last     <= rd_last_next;
      done        <= done_next;
      if (cfg_we) begin
        timeout <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    sum       <= sum_next;
    idx       <= idx_next;
    result    <= result_next;
    cur_seq   <= cur_seq_next;
    cur_plen  <= cur_plen_next;
    cur_bytes <= cur_bytes_next;
  end

  // Chunks of a completed packet come out on back-to-back cycles
  a_chunk_stream: assert property (@(posedge clk) disable iff (rst)
    done && !result.last |=> done)
    else $error("chunk stream broken before last result");

  // The block only goes idle together with the final result of its item
  a_idle_on_last: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done && result.last)
    else $error("busy dropped without a final result");

  // No slot is marked received outside a packet
  a_mask_clear: assert property (@(posedge clk) disable iff (rst)
    !in_progress |-> got_mask == '0)
    else $error("received mask set while no packet in progress");

  // Only completed-packet chunks can be followed by more results
  a_single_simple: assert property (@(posedge clk) disable iff (rst)
    done && result.status != cfr_pkg::STATUS_DONE |-> result.last)
    else $error("non-chunk result not flagged last");

endmodule
`default_nettype wire

// ----- bench/cfr_reassembly_checker.sv -----
// Checker for the CAN fragment reassembler: predicts each frame's results and compares them.
module cfr_reassembly_checker
  import cfr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire item_t       item,
  input  wire logic        done,
  input  wire result_t     result,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  output int               mismatches,
  output int               outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0] timeout_copy;
  bit          assembling;
  int unsigned frag_total;
  bit          slot_full  [MAX_PARTS];
  logic [2:0]  slot_len   [MAX_PARTS];
  logic [7:0]  slot_bytes [MAX_PARTS][CHUNK_BYTES];
  logic [10:0] last_id;
  logic [7:0]  seen_seq;
  logic [31:0] last_ms;
  result_t     expected_chunks [$];

  function automatic result_t status_only(status_t s);
    result_t r;
    r = '0;
    r.status = s;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic logic [7:0] chunk_byte(int slot, int b);
    return (b < slot_len[slot]) ? slot_bytes[slot][b] : 8'h00;
  endfunction

  task automatic drop_packet();
    assembling = 1'b0;
    foreach (slot_full[i]) slot_full[i] = 1'b0;
  endtask

  task automatic predict_reassembly(input item_t f);
    int unsigned dlc;
    int unsigned total;
    int unsigned seq;
    int unsigned nbytes;
    int unsigned sum;
    logic [31:0] gap;
    result_t     r;
    dlc = 32'((f.length_code > DLC_MAX) ? DLC_MAX : f.length_code);
    total = (int'(f.count_minus_one) + 1) % 256;
    seq = 32'(f.sequence_req);
    if (dlc < HDR_BYTES || total == 0 || total > MAX_PARTS) begin
      expected_chunks.push_back(status_only(STATUS_REJECT));
      return;
    end
    // restart on idle or on a gap past the timeout, taking this frame's count
    gap = f.now_ms - last_ms;
    if (!assembling || gap > timeout_copy) begin
      drop_packet();
      assembling = 1'b1;
      frag_total = total;
    end
    if (seq >= frag_total) begin
      expected_chunks.push_back(status_only(STATUS_REJECT));
      return;
    end
    if (f.frame_id == last_id && f.sequence_req == seen_seq) begin
      expected_chunks.push_back(status_only(STATUS_PEND));
      return;
    end
    nbytes = dlc - HDR_BYTES;
    if (nbytes > CHUNK_BYTES) nbytes = CHUNK_BYTES;
    last_id = f.frame_id;
    seen_seq = f.sequence_req;
    last_ms = f.now_ms;
    slot_full[seq] = 1'b1;
    slot_len[seq] = 3'(nbytes);
    slot_bytes[seq][0] = f.data_0;
    slot_bytes[seq][1] = f.data_1;
    slot_bytes[seq][2] = f.data_2;
    slot_bytes[seq][3] = f.data_3;
    slot_bytes[seq][4] = f.data_4;
    slot_bytes[seq][5] = f.data_5;
    sum = 0;
    for (int i = 0; i < frag_total; i++) begin
      if (!slot_full[i]) begin
        expected_chunks.push_back(status_only(STATUS_PEND));
        return;
      end
      sum += slot_len[i];
    end
    for (int i = 0; i < frag_total; i++) begin
      r = '0;
      r.status = STATUS_DONE;
      r.chunk_len = slot_len[i];
      r.out_0 = chunk_byte(i, 0);
      r.out_1 = chunk_byte(i, 1);
      r.out_2 = chunk_byte(i, 2);
      r.out_3 = chunk_byte(i, 3);
      r.out_4 = chunk_byte(i, 4);
      r.out_5 = chunk_byte(i, 5);
      r.packet_len = 8'(sum);
      r.last = (i == frag_total - 1);
      expected_chunks.push_back(r);
    end
    drop_packet();
  endtask

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic compare_chunk(input result_t want, input result_t got);
    compare_field("status", 32'(want.status), 32'(got.status));
    compare_field("chunk_len", 32'(want.chunk_len), 32'(got.chunk_len));
    compare_field("out_0", 32'(want.out_0), 32'(got.out_0));
    compare_field("out_1", 32'(want.out_1), 32'(got.out_1));
    compare_field("out_2", 32'(want.out_2), 32'(got.out_2));
    compare_field("out_3", 32'(want.out_3), 32'(got.out_3));
    compare_field("out_4", 32'(want.out_4), 32'(got.out_4));
    compare_field("out_5", 32'(want.out_5), 32'(got.out_5));
    compare_field("packet_len", 32'(want.packet_len), 32'(got.packet_len));
    compare_field("last", 32'(want.last), 32'(got.last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      timeout_copy = TIMEOUT_RESET;
      drop_packet();
      frag_total = 0;
      last_id = '0;
      seen_seq = '0;
      last_ms = '0;
      expected_chunks.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) timeout_copy = cfg_wdata;
      if (start && !busy) predict_reassembly(item);
      if (done) begin
        if (expected_chunks.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %0h", $time, result);
          mismatches++;
        end else begin
          compare_chunk(expected_chunks.pop_front(), result);
        end
      end
    end
    outstanding = expected_chunks.size();
  end

endmodule

// ----- bench/can_fragment_reassembler_unit_tb.sv -----
// Testbench top for the CAN fragment reassembler: clock, reset, frame stimulus and verdict.
module can_fragment_reassembler_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cfr_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  item_t       item;
  logic        done;
  result_t     result;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  int          mismatches;
  int          outstanding;
  int          frames_sent;
  int          burst_left;
  int unsigned cycles;
  logic [31:0] ms_clock;
  logic [31:0] tmo_now;

  can_fragment_reassembler_unit dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  cfr_reassembly_checker chunk_check (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .item        (item),
    .done        (done),
    .result      (result),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("can_fragment_reassembler_unit_tb: FAIL");
      $finish;
    end
  end

  function automatic item_t build_frame(logic [10:0] id, logic [3:0] dlc, logic [7:0] cm1,
                                        logic [7:0] seq, logic [47:0] payload,
                                        logic [31:0] ms);
    item_t f;
    f.frame_id = id;
    f.length_code = dlc;
    f.count_minus_one = cm1;
    f.sequence_req = seq;
    {f.data_0, f.data_1, f.data_2, f.data_3, f.data_4, f.data_5} = payload;
    f.now_ms = ms;
    return f;
  endfunction

  // Hold start high until the block takes the item; start may drop for a random gap between bursts.
  task automatic send_frame(input item_t f);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        start <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    start <= 1'b1;
    item <= f;
    do begin
      @(posedge clk);
    end while (busy);
    frames_sent++;
  endtask

  // Mostly small steps; now and then a jump past, or exactly at, the timeout, or to a random time.
  task automatic advance_ms();
    int pick;
    pick = $urandom_range(0, 24);
    case (pick)
      0:       ms_clock += tmo_now + 1;
      1:       ms_clock += tmo_now;
      2:       ms_clock = $urandom;
      default: ms_clock += (tmo_now >= 8) ? $urandom_range(0, 8) : 0;
    endcase
  endtask

  function automatic logic [3:0] pick_dlc();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 4'($urandom_range(9, 15));
    if (r < 3) return 4'($urandom_range(2, 7));
    return DLC_MAX;
  endfunction

  task automatic send_noise();
    logic [47:0] payload;
    payload = 48'({$urandom, $urandom});
    advance_ms();
    send_frame(build_frame(11'($urandom), 4'($urandom), 8'($urandom), 8'($urandom),
                           payload, ms_clock));
  endtask

  // One packet in shuffled order; sometimes repeat a frame, give a wrong count or abandon the packet.
  task automatic send_packet();
    int          total;
    int          order [MAX_PARTS];
    int          j;
    int          tmp;
    logic [10:0] id;
    logic [7:0]  cm1;
    logic [47:0] payload;
    item_t       f;
    total = ($urandom_range(0, 11) == 0) ? $urandom_range(6, MAX_PARTS) : $urandom_range(1, 5);
    id = 11'($urandom);
    for (int k = 0; k < total; k++) order[k] = k;
    for (int k = total - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    for (int k = 0; k < total; k++) begin
      if ($urandom_range(0, 19) == 0) break;
      advance_ms();
      cm1 = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'(total - 1);
      payload = 48'({$urandom, $urandom});
      f = build_frame(id, pick_dlc(), cm1, 8'(order[k]), payload, ms_clock);
      send_frame(f);
      if ($urandom_range(0, 11) == 0) send_frame(f);
    end
  endtask

  task automatic run_random(input int n);
    int stop;
    stop = frames_sent + n;
    while (frames_sent < stop) begin
      if ($urandom_range(0, 7) == 0) send_noise();
      else send_packet();
    end
  endtask

  // Change the timeout only once the block has drained.
  task automatic write_timeout(input logic [31:0] value);
    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0 || busy) @(negedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    tmo_now = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_directed();
    // identifier 0, sequence 0 right after reset counts as a repeat
    send_frame(build_frame(11'd0, 4'd8, 8'd0, 8'd0, 48'h0, 32'd100));
    // short frames
    send_frame(build_frame(11'h7FF, 4'd1, 8'd0, 8'd0, 48'hFFFF_FFFF_FFFF, 32'd100));
    send_frame(build_frame(11'h7FF, 4'd0, 8'd0, 8'd0, 48'hFFFF_FFFF_FFFF, 32'd100));
    // count wraps to zero, then one above the slot limit
    send_frame(build_frame(11'd3, 4'd8, 8'hFF, 8'd0, 48'h0102_0304_0506, 32'd100));
    send_frame(build_frame(11'd3, 4'd8, 8'd32, 8'd0, 48'h0102_0304_0506, 32'd100));
    // single-frame packets: saturated length, then an empty chunk
    send_frame(build_frame(11'd5, 4'hF, 8'd0, 8'd0, 48'hFFFF_FFFF_FFFF, 32'd110));
    send_frame(build_frame(11'd6, 4'd2, 8'd0, 8'd0, 48'h1234_5678_9ABC, 32'd120));
    // sequence out of range, restart stays in effect
    send_frame(build_frame(11'd7, 4'd8, 8'd31, 8'd40, 48'h0, 32'd130));
    send_frame(build_frame(11'd7, 4'd8, 8'd31, 8'hFF, 48'h0, 32'd130));
    // three fragments out of order after a timeout, with a repeat and a count mismatch
    send_frame(build_frame(11'd8, 4'd8, 8'd2, 8'd2, 48'hA1A2_A3A4_A5A6, 32'd1131));
    send_frame(build_frame(11'd8, 4'd5, 8'd2, 8'd0, 48'hB1B2_B3B4_B5B6, 32'd1141));
    send_frame(build_frame(11'd8, 4'd5, 8'd2, 8'd0, 48'hC1C2_C3C4_C5C6, 32'd1142));
    send_frame(build_frame(11'd8, 4'd7, 8'd9, 8'd1, 48'hD1D2_D3D4_D5D6, 32'd1150));
    // timeout mid packet restarts with the new count
    send_frame(build_frame(11'd9, 4'd8, 8'd1, 8'd0, 48'h1111_2222_3333, 32'd1200));
    send_frame(build_frame(11'd9, 4'd8, 8'd0, 8'd1, 48'h4444_5555_6666, 32'd2201));
    send_frame(build_frame(11'd10, 4'd8, 8'd0, 8'd0, 48'h7777_8888_9999, 32'd2201));
    // millisecond counter wraps
    send_frame(build_frame(11'd11, 4'd8, 8'd1, 8'd0, 48'h0F0F_0F0F_0F0F, 32'hFFFF_FFFF));
    send_frame(build_frame(11'd12, 4'd6, 8'd1, 8'd1, 48'hF0F0_F0F0_F0F0, 32'd0));
    // gap exactly at the timeout keeps the packet
    send_frame(build_frame(11'd13, 4'd8, 8'd1, 8'd0, 48'h5A5A_5A5A_5A5A, 32'd500));
    send_frame(build_frame(11'd14, 4'd3, 8'd1, 8'd1, 48'hA5A5_A5A5_A5A5, 32'd1500));
    ms_clock = 32'd1500;
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    frames_sent = 0;
    burst_left = 0;
    ms_clock = '0;
    tmo_now = TIMEOUT_RESET;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    run_directed();
    run_random(50);
    write_timeout(32'hFFFF_FFFF);
    run_random(45);
    write_timeout(32'h0);
    run_random(45);
    write_timeout(32'($urandom_range(5, 300)));
    run_random(45);
    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (mismatches == 0) begin
      $display("can_fragment_reassembler_unit_tb: PASS");
    end else begin
      $display("can_fragment_reassembler_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/cfr_pkg.sv
src/cfr_ram.sv
src/can_fragment_reassembler_unit.sv
bench/cfr_reassembly_checker.sv
bench/can_fragment_reassembler_unit_tb.sv
